/* design/lrc_pkg.sv */
// Shared types and command codes for the LED ring canvas renderer.
package lrc_pkg;

    // Command codes.
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_FILL  = 3'd1;
    localparam logic [2:0] CMD_SCALE = 3'd2;
    localparam logic [2:0] CMD_POINT = 3'd3;
    localparam logic [2:0] CMD_ARC   = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // One pixel: R in the top channel, then G, B and W.
    typedef logic [63:0] pixel_t;
    typedef logic [15:0] chan_t;

endpackage

/* design/lrc_canvas.sv */
// Pixel memory with per-pixel valid bits; a pixel that is not valid reads as zero.
module lrc_canvas #(
    parameter int PIXEL_COUNT = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           wr_en,
    input  logic [$clog2(PIXEL_COUNT)-1:0] wr_addr,
    input  lrc_pkg::pixel_t                wr_data,
    input  logic [$clog2(PIXEL_COUNT)-1:0] rd_addr,
    output lrc_pkg::pixel_t                rd_data
);
    import lrc_pkg::*;

    pixel_t                   mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0]   valid_reg;
    pixel_t                   rd_q_reg;
    logic                     rd_vld_reg;

    // Valid bits: a clear drops them all at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // Storage array with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

/* design/led_ring_canvas_renderer.sv */
// Top level of the LED ring canvas renderer: command sequencer and shared multiplier.
//
//  Channel   Signals                                         Direction  Transfer
//  command   start, busy, command, angle, extent, factor,    in         start && !busy
//            color_r/g/b/w, pixel_index
//  result    done, pixel_r/g/b/w                             out        done (one cycle)
//
// Clear, unknown commands and zero-span arcs go straight to done; read fetches one pixel,
// fill writes every pixel, and scale, arc and point visit each pixel in turn. An arc pixel
// that is not covered skips the channel update; a point pixel outside the falloff skips the
// 17-step restoring divider and the single multiplier that serves weight and channel products.
// Reset clears the canvas at once through per-pixel valid bits; no sweep is needed.
// The receiver cannot stall: done is high for exactly one cycle per command.
module led_ring_canvas_renderer #(
    parameter int PIXEL_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] angle,
    input  logic [16:0] extent,
    input  logic [15:0] factor,
    input  logic [15:0] color_r,
    input  logic [15:0] color_g,
    input  logic [15:0] color_b,
    input  logic [15:0] color_w,
    input  logic [7:0]  pixel_index,
    output logic        done,
    output logic [15:0] pixel_r,
    output logic [15:0] pixel_g,
    output logic [15:0] pixel_b,
    output logic [15:0] pixel_w
);
    import lrc_pkg::*;

    localparam int AW = $clog2(PIXEL_COUNT);
    localparam int GW = AW + 19;
    localparam logic [GW-1:0] TURN = GW'(PIXEL_COUNT) << 16;
    localparam logic [GW-1:0] HALF = GW'(32768);
    localparam logic [GW-1:0] PIXW = GW'(65536);
    localparam logic [AW-1:0] LAST = AW'(PIXEL_COUNT - 1);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_FILL = 14'b00000000000010,
        S_RD   = 14'b00000000000100,
        S_RDW  = 14'b00000000001000,
        S_COV  = 14'b00000000010000,
        S_DIV  = 14'b00000000100000,
        S_SQ   = 14'b00000001000000,
        S_CUBE = 14'b00000010000000,
        S_WGT  = 14'b00000100000000,
        S_CH   = 14'b00001000000000,
        S_ACC  = 14'b00010000000000,
        S_WR   = 14'b00100000000000,
        S_NEXT = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      cmd_reg;
    logic [15:0]     factor_reg;
    chan_t           col_reg [4];
    logic [AW-1:0]   idx_reg;
    logic            idx_ok_reg;
    logic [GW-1:0]   f_reg, s_reg, pos_reg;
    logic [AW-1:0]   pix_reg;
    chan_t           ch_reg [4];
    logic [1:0]      k_reg;
    logic [GW-1:0]   rem_reg, cov1_reg, cov2_reg;
    logic [16:0]     q_reg;
    logic [4:0]      cnt_reg;
    logic [16:0]     w_reg;
    logic [51:0]     prod_reg;
    chan_t           res_reg [4];

    logic            accept;
    logic [16:0]     ext_c;
    logic [GW-1:0]   centre, x0, x, d, lo1, hi1, h2, cov_sum, rem_sub;
    logic            ge;
    logic [33:0]     mul_a;
    logic [17:0]     mul_b;
    logic [37:0]     scaled;
    logic [35:0]     add_amt;
    logic [16:0]     sum_ch;
    chan_t           new_ch;
    pixel_t          rd_data;
    pixel_t          wr_data;
    logic            wr_en;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign ext_c  = (extent > 17'd65536) ? 17'd65536 : extent;

    // Ring geometry for the current pixel.
    always_comb
    begin
        centre = (GW'(pix_reg) << 16) + HALF;
        x0     = centre + TURN - pos_reg;
        x      = (x0 >= TURN) ? x0 - TURN : x0;
        d      = (x > (TURN >> 1)) ? TURN - x : x;
        lo1    = (x >= HALF) ? x - HALF : '0;
        hi1    = (x + HALF < s_reg) ? x + HALF : s_reg;
        h2     = (x + HALF - TURN < s_reg) ? x + HALF - TURN : s_reg;
        cov_sum = cov1_reg + cov2_reg;
        ge      = (rem_reg >= f_reg);
        rem_sub = ge ? rem_reg - f_reg : rem_reg;
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = 34'(q_reg);
                mul_b = 18'(q_reg);
            end
            S_CUBE:
            begin
                mul_a = prod_reg[33:0];
                mul_b = 18'(196608) - {q_reg, 1'b0};
            end
            S_CH:
            begin
                if (cmd_reg == CMD_SCALE)
                begin
                    mul_a = 34'(ch_reg[k_reg]);
                    mul_b = 18'(factor_reg);
                end
                else
                begin
                    mul_a = 34'(col_reg[k_reg]);
                    mul_b = 18'(w_reg);
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Channel update with rounding and saturation.
    always_comb
    begin
        scaled  = 38'((prod_reg + 52'd8192) >> 14);
        add_amt = 36'((prod_reg + 52'd32768) >> 16);
        sum_ch  = 17'(ch_reg[k_reg]) + 17'(add_amt);
        if (cmd_reg == CMD_SCALE)
        begin
            new_ch = (scaled > 38'd65535) ? 16'hFFFF : scaled[15:0];
        end
        else
        begin
            new_ch = (add_amt > 36'd65535 || sum_ch[16]) ? 16'hFFFF : sum_ch[15:0];
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_FILL:  state_next = S_FILL;
                        CMD_SCALE: state_next = S_RD;
                        CMD_POINT: state_next = S_RD;
                        CMD_ARC:   state_next = (extent == '0) ? S_DONE : S_RD;
                        CMD_READ:  state_next = S_RD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_FILL:  state_next = (pix_reg == LAST) ? S_DONE : S_FILL;
            S_RD:    state_next = S_RDW;
            S_RDW:
            begin
                case (cmd_reg)
                    CMD_READ:  state_next = S_DONE;
                    CMD_SCALE: state_next = S_CH;
                    CMD_ARC:   state_next = S_COV;
                    default:   state_next = (d < f_reg) ? S_DIV : S_NEXT;
                endcase
            end
            S_COV:   state_next = (cov_sum == '0) ? S_NEXT : S_CH;
            S_DIV:   state_next = (cnt_reg == '0) ? S_SQ : S_DIV;
            S_SQ:    state_next = S_CUBE;
            S_CUBE:  state_next = S_WGT;
            S_WGT:   state_next = S_CH;
            S_CH:    state_next = S_ACC;
            S_ACC:   state_next = (k_reg == 2'd3) ? S_WR : S_CH;
            S_WR:    state_next = S_NEXT;
            S_NEXT:  state_next = (pix_reg == LAST) ? S_DONE : S_RD;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_CLEAR;
            pix_reg   <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cmd_reg <= command;
                pix_reg <= '0;
            end
            if (state_reg == S_FILL || state_reg == S_NEXT)
            begin
                pix_reg <= pix_reg + AW'(1);
            end
            if (state_reg == S_RDW)
            begin
                k_reg   <= '0;
                cnt_reg <= 5'd16;
            end
            if (state_reg == S_COV || state_reg == S_WGT)
            begin
                k_reg <= '0;
            end
            if (state_reg == S_ACC)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= 52'(mul_a) * 52'(mul_b);
        if (accept)
        begin
            factor_reg <= factor;
            col_reg[0] <= color_r;
            col_reg[1] <= color_g;
            col_reg[2] <= color_b;
            col_reg[3] <= color_w;
            idx_reg    <= pixel_index[AW-1:0];
            idx_ok_reg <= ({1'b0, pixel_index} < 9'(PIXEL_COUNT));
            f_reg      <= (extent == '0) ? PIXW : GW'(extent) * GW'(PIXEL_COUNT);
            s_reg      <= GW'(ext_c) * GW'(PIXEL_COUNT);
            pos_reg    <= GW'(angle) * GW'(PIXEL_COUNT);
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        if (state_reg == S_RDW)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ch_reg[i] <= rd_data[63-16*i -: 16];
            end
            if (cmd_reg == CMD_READ && idx_ok_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res_reg[i] <= rd_data[63-16*i -: 16];
                end
            end
            rem_reg  <= f_reg - d;
            q_reg    <= '0;
            cov1_reg <= (hi1 > lo1) ? hi1 - lo1 : '0;
            cov2_reg <= (x + HALF > TURN) ? h2 : '0;
        end
        if (state_reg == S_DIV)
        begin
            q_reg   <= {q_reg[15:0], ge};
            rem_reg <= rem_sub << 1;
        end
        if (state_reg == S_COV)
        begin
            w_reg <= (cov_sum > PIXW) ? 17'd65536 : cov_sum[16:0];
        end
        if (state_reg == S_WGT)
        begin
            w_reg <= 17'((prod_reg + 52'h80000000) >> 32);
        end
        if (state_reg == S_ACC)
        begin
            ch_reg[k_reg] <= new_ch;
        end
    end

    // Canvas write port.
    always_comb
    begin
        wr_en   = (state_reg == S_FILL) || (state_reg == S_WR);
        wr_data = (state_reg == S_FILL)
                ? {col_reg[0], col_reg[1], col_reg[2], col_reg[3]}
                : {ch_reg[0], ch_reg[1], ch_reg[2], ch_reg[3]};
    end

    lrc_canvas #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_canvas (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept && command == CMD_CLEAR),
        .wr_en   (wr_en),
        .wr_addr (pix_reg),
        .wr_data (wr_data),
        .rd_addr ((cmd_reg == CMD_READ) ? idx_reg : pix_reg),
        .rd_data (rd_data)
    );

    assign pixel_r = res_reg[0];
    assign pixel_g = res_reg[1];
    assign pixel_b = res_reg[2];
    assign pixel_w = res_reg[3];

endmodule

/* tb/led_ring_canvas_renderer_checker.sv */
// Canvas predictor and result checker for the LED ring canvas renderer.
`timescale 1ns / 1ps
module led_ring_canvas_renderer_checker #(
    parameter int PIXEL_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] angle,
    input  logic [16:0] extent,
    input  logic [15:0] factor,
    input  logic [15:0] color_r,
    input  logic [15:0] color_g,
    input  logic [15:0] color_b,
    input  logic [15:0] color_w,
    input  logic [7:0]  pixel_index,
    input  logic        done,
    input  logic [15:0] pixel_r,
    input  logic [15:0] pixel_g,
    input  logic [15:0] pixel_b,
    input  logic [15:0] pixel_w,
    output int          fail_count,
    output int          pending_reads
);
    import lrc_pkg::*;

    localparam longint PIX_W = 65536;
    localparam longint HALF_PIX = 32768;
    localparam longint TURN = PIX_W * PIXEL_COUNT;

    // Model copy of the canvas, channel 0 red through channel 3 white.
    chan_t canvas [PIXEL_COUNT][4];
    pixel_t expected_pixels [$];

    function automatic chan_t clamp16(longint v);
        return (v > 65535) ? 16'hFFFF : chan_t'(v);
    endfunction

    // Add a color weighted by an unsigned Q1.16 weight (up to 1.0) to one pixel.
    task automatic blend_in(int idx, chan_t col [4], longint w);
        for (int ch = 0; ch < 4; ch++)
            canvas[idx][ch] = clamp16(longint'(canvas[idx][ch])
                                      + ((col[ch] * w + 32768) >>> 16));
    endtask

    function automatic longint arc_overlap_len(longint lo, longint hi, longint a, longint b);
        longint l;
        longint h;
        l = (lo > a) ? lo : a;
        h = (hi < b) ? hi : b;
        return (h > l) ? h - l : 0;
    endfunction

    // Apply one command to the canvas and return the expected read value.
    task automatic render_command(logic [2:0] cmd, longint ang, longint ext, longint fac,
                                  chan_t col [4], int idx, output pixel_t result);
        longint f;
        longint pos;
        longint x;
        longint d;
        longint t;
        longint w;
        longint s;
        longint rel;
        longint cov;
        result = '0;
        case (cmd)
            CMD_CLEAR:
                for (int i = 0; i < PIXEL_COUNT; i++)
                    for (int ch = 0; ch < 4; ch++) canvas[i][ch] = '0;
            CMD_FILL:
                for (int i = 0; i < PIXEL_COUNT; i++)
                    for (int ch = 0; ch < 4; ch++) canvas[i][ch] = col[ch];
            CMD_SCALE:
                for (int i = 0; i < PIXEL_COUNT; i++)
                    for (int ch = 0; ch < 4; ch++)
                        canvas[i][ch] = clamp16((canvas[i][ch] * fac + 8192) >>> 14);
            CMD_POINT:
            begin
                f = (ext == 0) ? PIX_W : ext * PIXEL_COUNT;
                pos = (ang * PIXEL_COUNT) % TURN;
                for (int i = 0; i < PIXEL_COUNT; i++)
                begin
                    x = ((2 * i + 1) * HALF_PIX + TURN - pos) % TURN;
                    d = (x > TURN / 2) ? TURN - x : x;
                    if (d < f)
                    begin
                        t = ((f - d) << 16) / f;
                        w = (t * t * (3 * 65536 - 2 * t) + 64'h8000_0000) >>> 32;
                        blend_in(i, col, w);
                    end
                end
            end
            CMD_ARC:
                if (ext != 0)
                begin
                    s = ((ext > 65536) ? 65536 : ext) * PIXEL_COUNT;
                    pos = (ang * PIXEL_COUNT) % TURN;
                    for (int i = 0; i < PIXEL_COUNT; i++)
                    begin
                        rel = ((2 * i + 1) * HALF_PIX + TURN - pos) % TURN;
                        cov = arc_overlap_len(rel - HALF_PIX, rel + HALF_PIX, 0, s)
                            + arc_overlap_len(rel - TURN - HALF_PIX,
                                              rel - TURN + HALF_PIX, 0, s);
                        if (cov > PIX_W) cov = PIX_W;
                        if (cov > 0) blend_in(i, col, cov);
                    end
                end
            CMD_READ:
                if (idx < PIXEL_COUNT)
                    result = {canvas[idx][0], canvas[idx][1], canvas[idx][2], canvas[idx][3]};
            default: ;
        endcase
    endtask

    // Predict on each command transfer, compare on each result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        chan_t col [4];
        pixel_t predicted;
        pixel_t seen;
        if (!rst_n)
        begin
            for (int i = 0; i < PIXEL_COUNT; i++)
                for (int ch = 0; ch < 4; ch++) canvas[i][ch] = '0;
            expected_pixels.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                seen = {pixel_r, pixel_g, pixel_b, pixel_w};
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with none expected: %h", $realtime, seen);
                end
                else
                begin
                    predicted = expected_pixels.pop_front();
                    if (seen !== predicted)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch r/g/b/w expected %h %h %h %h got %h %h %h %h",
                                     $realtime, predicted[63:48], predicted[47:32],
                                     predicted[31:16], predicted[15:0],
                                     pixel_r, pixel_g, pixel_b, pixel_w);
                    end
                end
            end
            if (start && !busy)
            begin
                col[0] = color_r;
                col[1] = color_g;
                col[2] = color_b;
                col[3] = color_w;
                render_command(command, angle, extent, factor, col, pixel_index, predicted);
                expected_pixels.push_back(predicted);
            end
        end
        pending_reads = expected_pixels.size();
    end

endmodule

/* tb/led_ring_canvas_renderer_tb.sv */
// Stimulus and verdict for the LED ring canvas renderer testbench.
`timescale 1ns / 1ps
module led_ring_canvas_renderer_tb;
    import lrc_pkg::*;

    localparam int PIXELS = 32;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [15:0] angle;
    logic [16:0] extent;
    logic [15:0] factor;
    logic [15:0] color_r;
    logic [15:0] color_g;
    logic [15:0] color_b;
    logic [15:0] color_w;
    logic [7:0]  pixel_index;
    logic        done;
    logic [15:0] pixel_r;
    logic [15:0] pixel_g;
    logic [15:0] pixel_b;
    logic [15:0] pixel_w;
    int          fail_count;
    int          pending_reads;
    int          quiet_cycles;
    bit          timed_out;

    led_ring_canvas_renderer #(.PIXEL_COUNT(PIXELS)) dut (.*);
    led_ring_canvas_renderer_checker #(.PIXEL_COUNT(PIXELS)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // Drive one command and hold it until the transfer.
    task automatic send_command(logic [2:0] cmd, logic [15:0] ang, logic [16:0] ext,
                                logic [15:0] fac, logic [63:0] col, logic [7:0] idx,
                                bit allow_gaps);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        angle <= ang;
        extent <= ext;
        factor <= fac;
        {color_r, color_g, color_b, color_w} <= col;
        pixel_index <= idx;
        // Busy is steady at the falling edge; the next rising edge after an idle one
        // takes the transfer.
        while (busy) @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 3))
            0: return 16'hFFFF;
            1: return 16'(($urandom_range(0, 4096)));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_extent();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'($urandom_range(0, 3000));
            2: return 17'($urandom_range(65530, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Random item: mostly drawing commands and reads, with other commands mixed in.
    task automatic send_random(bit allow_gaps);
        logic [2:0] cmd;
        logic [7:0] idx;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) cmd = CMD_READ;
        else if (pick < 55) cmd = CMD_POINT;
        else if (pick < 75) cmd = CMD_ARC;
        else if (pick < 84) cmd = CMD_SCALE;
        else if (pick < 92) cmd = CMD_FILL;
        else if (pick < 96) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(6, 7));
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, PIXELS - 1));
        send_command(cmd, 16'($urandom), rand_extent(),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20000)) : 16'($urandom),
                     {rand_chan(), rand_chan(), rand_chan(), rand_chan()}, idx, allow_gaps);
    endtask

    task automatic read_all();
        for (int i = 0; i < PIXELS; i++)
            send_command(CMD_READ, '0, '0, '0, '0, 8'(i), 1'b0);
    endtask

    // Stimulus.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_CLEAR;
        angle = '0;
        extent = '0;
        factor = '0;
        color_r = '0;
        color_g = '0;
        color_b = '0;
        color_w = '0;
        pixel_index = '0;
        timed_out = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        fork
        begin
            // Directed part: a fill, scale extremes, points, a clear, arcs with wrap, reads, unknown commands.
            send_command(CMD_READ, '0, '0, '0, '0, 8'd0, 1'b0);
            send_command(CMD_FILL, '0, '0, '0, 64'hFFFF_0001_8000_4000, '0, 1'b0);
            send_command(CMD_SCALE, '0, '0, 16'hFFFF, '0, '0, 1'b0);
            send_command(CMD_READ, '0, '0, '0, '0, 8'd31, 1'b0);
            send_command(CMD_SCALE, '0, '0, 16'h0000, '0, '0, 1'b0);
            send_command(CMD_POINT, 16'h0000, 17'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
            send_command(CMD_POINT, 16'hFFFF, 17'h1FFFF, '0, 64'h1234_8000_00FF_FFFF, '0, 1'b0);
            send_command(CMD_READ, '0, '0, '0, '0, 8'd0, 1'b0);
            send_command(CMD_CLEAR, '0, '0, '0, '0, '0, 1'b0);
            send_command(CMD_ARC, 16'hF000, 17'h02000, '0, 64'hFFFF_4000_2000_0001, '0, 1'b0);
            send_command(CMD_ARC, 16'h1234, 17'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
            send_command(CMD_ARC, 16'h0800, 17'h1FFFF, '0, 64'h0100_0200_0300_0400, '0, 1'b0);
            send_command(CMD_READ, '0, '0, '0, '0, 8'd31, 1'b0);
            send_command(CMD_READ, '0, '0, '0, '0, 8'hFF, 1'b0);
            send_command(CMD_READ, '0, '0, '0, '0, 8'd32, 1'b0);
            send_command(3'd6, '0, '0, '0, '0, '0, 1'b0);
            send_command(3'd7, 16'hFFFF, 17'h1FFFF, 16'hFFFF, '1, 8'hFF, 1'b0);
            read_all();

            // Random part with sender gaps until the last hundred items, one full drain halfway.
            for (int n = 0; n < 900; n++)
            begin
                if (n == 450)
                begin
                    start <= 1'b0;
                    @(negedge clk);
                    while (pending_reads != 0) @(negedge clk);
                    read_all();
                end
                send_random(n < 800);
            end
            start <= 1'b0;
            while (pending_reads != 0) @(negedge clk);
            repeat (10) @(negedge clk);
        end
        begin
            while (quiet_cycles < STALL_LIMIT) @(negedge clk);
            timed_out = 1'b1;
        end
        join_any

        if (timed_out || pending_reads != 0)
            $display("[FAIL] regression broken");
        else if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* led_ring_canvas_renderer.f */
design/lrc_pkg.sv
design/lrc_canvas.sv
design/led_ring_canvas_renderer.sv
tb/led_ring_canvas_renderer_checker.sv
tb/led_ring_canvas_renderer_tb.sv
